/* rtl/cicds_pkg.sv */
// ============================================================================
// cicds_pkg - shared types and constants for the CIC shift correction core
// Field widths, register indexes, the result layout and the status structs
// passed between the sequencer and its arithmetic units.
// ============================================================================
package cicds_pkg;

    localparam int NUM_W      = 32;
    localparam int DEN_W      = 26;
    localparam int LEN_W      = 16;
    localparam int EVR_W      = 24;
    localparam int PLL_W      = 10;
    localparam int RF_W       = 10;
    localparam int STG_W      = 3;
    localparam int BLD_W      = 10;
    localparam int SHIFT_W    = 4;
    localparam int GROWTH_W   = 7;
    localparam int LIMB_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int OUT_W      = 56;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EVR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUILD = 3'd4;

    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd15;

    // result beat, apply in bit 0
    typedef struct packed {
        logic                  zero_divisor;
        logic                  not_integer;
        logic                  scale_overflow;
        logic [GROWTH_W-1:0]   actual_shift;
        logic [GROWTH_W-1:0]   build_shift;
        logic [NUM_W-1:0]      actual_decimation;
        logic [SHIFT_W-1:0]    new_shift;
        logic                  apply;
    } result_t;

    typedef struct packed {
        logic                done;
        logic                not_integer;
        logic [NUM_W-1:0]    quotient;
    } div_stat_t;

    typedef struct packed {
        logic                done;
        logic [GROWTH_W-1:0] growth;
    } growth_stat_t;

    // index of the highest set bit of a limb, 0 when the limb is zero
    function automatic logic [4:0] top_bit32(input logic [LIMB_W-1:0] v);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 0; i < LIMB_W; i++)
        begin
            if (v[i])
            begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* rtl/cicds_div.sv */
// ============================================================================
// cicds_div - restoring divider, one quotient bit per cycle
// Divides the 32-bit numerator by the 26-bit denominator and reports the
// quotient and whether the remainder is nonzero.
// ============================================================================
module cicds_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [cicds_pkg::NUM_W-1:0]    num,
    input  logic [cicds_pkg::DEN_W-1:0]    den,
    output cicds_pkg::div_stat_t           stat
);

    logic [cicds_pkg::DEN_W-1:0] rem_reg,  rem_next;
    logic [cicds_pkg::NUM_W-1:0] quo_reg,  quo_next;
    logic [cicds_pkg::DEN_W-1:0] den_reg;
    logic [4:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [cicds_pkg::DEN_W:0]   shifted;
    logic [cicds_pkg::DEN_W+1:0] diff;
    logic                        ge;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[cicds_pkg::NUM_W-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        ge       = !diff[cicds_pkg::DEN_W+1];
        rem_next = ge ? diff[cicds_pkg::DEN_W-1:0] : shifted[cicds_pkg::DEN_W-1:0];
        quo_next = {quo_reg[cicds_pkg::NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.done        = done_reg;
    assign stat.not_integer = |rem_reg;
    assign stat.quotient    = quo_reg;

endmodule

/* rtl/cicds_growth.sv */
// ============================================================================
// cicds_growth - bit growth of a decimation factor raised to the stage count
// Raises d to the power n one 32x32 limb product per cycle, with a saturating
// step to 2^(POWER_WIDTH-1) per pass; a limb-wise scan then gives ceil(log2).
// ============================================================================
module cicds_growth #(
    parameter int POWER_WIDTH = 72
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cicds_pkg::LIMB_W-1:0]  d,
    input  logic [cicds_pkg::STG_W-1:0]   n,
    output cicds_pkg::growth_stat_t       stat
);

    localparam int LIMBS  = (POWER_WIDTH + 31) / 32;
    localparam int PL     = LIMBS * 32;
    localparam int FW     = PL + 32;
    localparam int CAP    = POWER_WIDTH - 1;
    localparam int LIDX_W = $clog2(LIMBS);
    localparam int CAND_W = LIDX_W + 6;
    localparam logic [LIDX_W-1:0] LAST_LIMB = LIDX_W'(LIMBS - 1);

    localparam logic [2:0] G_IDLE = 3'd0;
    localparam logic [2:0] G_MUL  = 3'd1;
    localparam logic [2:0] G_SAT  = 3'd2;
    localparam logic [2:0] G_DEC  = 3'd3;
    localparam logic [2:0] G_SCAN = 3'd4;

    logic [2:0]                        state_reg;
    logic [LIDX_W-1:0]                 k_reg;
    logic [cicds_pkg::STG_W-1:0]       step_reg;
    logic [cicds_pkg::STG_W-1:0]       n_reg;
    logic [cicds_pkg::LIMB_W-1:0]      d_reg;
    logic [PL-1:0]                     p_reg;
    logic [PL-1:0]                     prod_reg;
    logic [PL-1:0]                     q_reg;
    logic [cicds_pkg::LIMB_W-1:0]      carry_reg;
    logic [cicds_pkg::GROWTH_W-1:0]    growth_reg;
    logic                              done_reg;

    logic [cicds_pkg::LIMB_W-1:0]      limb_p;
    logic [cicds_pkg::LIMB_W-1:0]      limb_q;
    logic [63:0]                       mprod;
    logic [63:0]                       t;
    logic [FW-1:0]                     full;
    logic                              sat;
    logic [PL-1:0]                     sat_val;
    logic [CAND_W-1:0]                 cand;

    always_comb
    begin
        limb_p  = p_reg[k_reg*32 +: 32];
        limb_q  = q_reg[k_reg*32 +: 32];
        mprod   = limb_p * d_reg;
        t       = mprod + {32'd0, carry_reg};
        full    = {carry_reg, prod_reg};
        sat     = (|full[FW-1:CAP+1]) | (full[CAP] & (|full[CAP-1:0]));
        sat_val = {{(PL-1){1'b0}}, 1'b1} << CAP;
        cand    = {1'b0, k_reg, cicds_pkg::top_bit32(limb_q)} + CAND_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                G_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= (n == '0) ? G_DEC : G_MUL;
                    end
                end
                G_MUL:
                begin
                    if (k_reg == LAST_LIMB)
                    begin
                        state_reg <= G_SAT;
                    end
                end
                G_SAT:
                begin
                    if (step_reg == 3'(n_reg - 3'd1))
                    begin
                        state_reg <= G_DEC;
                    end
                    else
                    begin
                        state_reg <= G_MUL;
                    end
                end
                G_DEC:
                begin
                    state_reg <= G_SCAN;
                end
                G_SCAN:
                begin
                    if ((limb_q != '0) || (k_reg == '0))
                    begin
                        state_reg <= G_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= G_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    d_reg     <= d;
                    n_reg     <= n;
                    p_reg     <= PL'(1);
                    step_reg  <= '0;
                    k_reg     <= '0;
                    carry_reg <= '0;
                end
            end
            G_MUL:
            begin
                prod_reg[k_reg*32 +: 32] <= t[31:0];
                carry_reg                <= t[63:32];
                if (k_reg != LAST_LIMB)
                begin
                    k_reg <= k_reg + LIDX_W'(1);
                end
            end
            G_SAT:
            begin
                // clamp anything above the top power of two
                p_reg     <= sat ? sat_val : full[PL-1:0];
                step_reg  <= step_reg + 3'd1;
                k_reg     <= '0;
                carry_reg <= '0;
            end
            G_DEC:
            begin
                q_reg <= (p_reg == '0) ? '0 : p_reg - PL'(1);
                k_reg <= LAST_LIMB;
            end
            G_SCAN:
            begin
                // bit length of p-1, top limb down
                if (limb_q != '0)
                begin
                    growth_reg <= cand[cicds_pkg::GROWTH_W-1:0];
                end
                else if (k_reg == '0)
                begin
                    growth_reg <= '0;
                end
                else
                begin
                    k_reg <= k_reg - LIDX_W'(1);
                end
            end
            default:
            begin
                k_reg <= '0;
            end
        endcase
    end

    assign stat.done   = done_reg;
    assign stat.growth = growth_reg;

endmodule

/* rtl/cic_decimation_shift_correction_core.sv */
// Flow: a zero divisor skips the arithmetic units; otherwise the 32-step divider
//   runs, then the shared limb multiplier works out the growth of the build
//   factor and then of the actual quotient.
// Throughput: one beat in at a time; the next is taken once the result is in the
//   output register, which may still be waiting for the sink.
// Reset: asynchronous active low; clears the sequencer, valid flags and config registers.
// ============================================================================
// cic_decimation_shift_correction_core - CIC decimation shift correction
// Works out the running decimation from the clock settings and table length,
// the bit growth of build and actual decimation and the correction shift.
// ============================================================================
module cic_decimation_shift_correction_core #(
    parameter int POWER_WIDTH = 72
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,    // [15:0] table_length
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] apply, [4:1] new_shift, [36:5] actual_decimation, [43:37] build_shift,
    // [50:44] actual_shift, [51] scale_overflow, [52] not_integer,
    // [53] zero_divisor, [55:54] zero
    output logic [cicds_pkg::OUT_W-1:0]        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cicds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cicds_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_BLD  = 3'd2;
    localparam logic [2:0] ST_ACT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                           state_reg;
    logic [cicds_pkg::EVR_W-1:0]          evr_reg;
    logic [cicds_pkg::PLL_W-1:0]          pll_reg;
    logic [cicds_pkg::RF_W-1:0]           rf_reg;
    logic [cicds_pkg::STG_W-1:0]          stg_reg;
    logic [cicds_pkg::BLD_W-1:0]          bld_reg;
    logic                                 zd_reg;
    logic [cicds_pkg::GROWTH_W-1:0]       bshift_reg;
    cicds_pkg::result_t                   out_reg;
    logic                                 m_tvalid_reg;

    logic                                 accept;
    logic                                 zero_den;
    logic [cicds_pkg::EVR_W+cicds_pkg::PLL_W-1:0] evr_pll;
    logic [cicds_pkg::NUM_W-1:0]          num_val;
    logic [cicds_pkg::DEN_W-1:0]          den_prod;
    logic                                 div_start;
    logic                                 g_start;
    logic [cicds_pkg::LIMB_W-1:0]         g_d;
    logic                                 out_load;
    cicds_pkg::div_stat_t                 div_stat;
    cicds_pkg::growth_stat_t              g_stat;
    cicds_pkg::result_t                   res;
    logic [cicds_pkg::GROWTH_W:0]         raw;
    logic                                 apply;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid & s_tready;
    assign zero_den  = (s_tdata == '0) || (rf_reg == '0);
    assign evr_pll   = evr_reg * pll_reg;
    assign num_val   = {evr_pll[cicds_pkg::NUM_W-3:0], 2'b00};
    assign den_prod  = s_tdata * rf_reg;
    assign div_start = accept & !zero_den;
    assign g_start   = ((state_reg == ST_DIV) && div_stat.done) ||
                       ((state_reg == ST_BLD) && g_stat.done);
    assign g_d       = (state_reg == ST_DIV) ? cicds_pkg::LIMB_W'(bld_reg) : div_stat.quotient;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // operands are captured by the divider on the accepting edge, unless the divisor is zero
    cicds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_val),
        .den   (den_prod),
        .stat  (div_stat)
    );

    // one growth unit, build factor first then the actual quotient
    cicds_growth #(
        .POWER_WIDTH (POWER_WIDTH)
    ) u_growth (
        .clk   (clk),
        .rst_n (rst_n),
        .start (g_start),
        .d     (g_d),
        .n     (stg_reg),
        .stat  (g_stat)
    );

    always_comb
    begin
        raw   = {1'b0, bshift_reg} - {1'b0, g_stat.growth};
        apply = div_stat.quotient != cicds_pkg::NUM_W'(bld_reg);
        res   = '0;
        if (zd_reg)
        begin
            res.zero_divisor = 1'b1;
        end
        else
        begin
            res.apply             = apply;
            res.actual_decimation = div_stat.quotient;
            res.build_shift       = bshift_reg;
            res.actual_shift      = g_stat.growth;
            res.not_integer       = div_stat.not_integer;
            if (apply)
            begin
                priority if (raw[cicds_pkg::GROWTH_W])
                begin
                    res.scale_overflow = 1'b1;
                end
                else if (raw[cicds_pkg::GROWTH_W-1:cicds_pkg::SHIFT_W] != '0)
                begin
                    res.new_shift = cicds_pkg::SHIFT_MAX;
                end
                else
                begin
                    res.new_shift = raw[cicds_pkg::SHIFT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evr_reg <= '0;
            pll_reg <= '0;
            rf_reg  <= '0;
            stg_reg <= '0;
            bld_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cicds_pkg::CFG_EVR:   evr_reg <= cfg_data;
                cicds_pkg::CFG_PLL:   pll_reg <= cfg_data[cicds_pkg::PLL_W-1:0];
                cicds_pkg::CFG_RF:    rf_reg  <= cfg_data[cicds_pkg::RF_W-1:0];
                cicds_pkg::CFG_STG:   stg_reg <= cfg_data[cicds_pkg::STG_W-1:0];
                cicds_pkg::CFG_BUILD: bld_reg <= cfg_data[cicds_pkg::BLD_W-1:0];
                default:              evr_reg <= evr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= zero_den ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_BLD;
                    end
                end
                ST_BLD:
                begin
                    if (g_stat.done)
                    begin
                        state_reg <= ST_ACT;
                    end
                end
                ST_ACT:
                begin
                    if (g_stat.done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    // hold until the output register is free
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            zd_reg <= zero_den;
        end
        if ((state_reg == ST_BLD) && g_stat.done)
        begin
            bshift_reg <= g_stat.growth;
        end
        if (out_load)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg};

    a_zero_div_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.zero_divisor |-> out_reg[cicds_pkg::OUT_W-4:0] == '0)
        else $error("zero divisor beat carries nonzero fields");

    a_shift_needs_apply: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_reg.new_shift != '0) |-> out_reg.apply)
        else $error("shift reported without apply");

    a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.scale_overflow |-> out_reg.apply && (out_reg.new_shift == '0))
        else $error("overflow beat with apply clear or nonzero shift");

    a_growth_when_used: assert property (@(posedge clk) disable iff (!rst_n)
        g_stat.done |-> (state_reg == ST_BLD) || (state_reg == ST_ACT))
        else $error("growth unit finished outside its sequencer slots");

    a_div_when_used: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside its sequencer slot");

endmodule
